/* rtl/core/sprd_pkg.sv */
// Sprite row pixel decoder package: payload structs and register index codes.
// No dependencies; compile first.
package sprd_pkg;

  // Widths fixed by the item formats
  localparam int unsigned RowBitsW = 24;
  localparam int unsigned ColorW   = 4;
  localparam int unsigned StartXW  = 9;
  localparam int unsigned PixelXW  = 10;
  localparam int unsigned LineW    = 8;
  localparam int unsigned CfgIdxW  = 2;

  // Multicolour bit pair codes
  localparam logic [1:0] PairClear  = 2'b00;
  localparam logic [1:0] PairShared1 = 2'b01;
  localparam logic [1:0] PairSprite = 2'b10;
  localparam logic [1:0] PairShared2 = 2'b11;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBackground = 2'd0,
    CfgSharedOne  = 2'd1,
    CfgSharedTwo  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [RowBitsW-1:0] row_bits;
    logic [ColorW-1:0]   sprite_color;
    logic                multicolor_mode;
    logic                expand_x;
    logic [StartXW-1:0]  start_x;
    logic [LineW-1:0]    screen_y;
  } row_item_t;

  typedef struct packed {
    logic [PixelXW-1:0] pixel_x;
    logic [LineW-1:0]   pixel_y;
    logic [ColorW-1:0]  pixel_color;
    logic               opaque;
    logic               last_pixel;
  } pix_item_t;

endpackage

/* rtl/core/sprd_if.sv */
// Valid/ready channel interfaces for the sprite row pixel decoder.
// Depends on sprd_pkg for the payload structs.
interface sprd_row_if import sprd_pkg::*; ();
  logic      valid;
  logic      ready;
  row_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sprd_pix_if import sprd_pkg::*; ();
  logic      valid;
  logic      ready;
  pix_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/sprite_row_pixel_decoder_core.sv */
// Sprite row pixel decoder top level: row register, column counter, output register.
// Depends on sprd_pkg and the channel interfaces in sprd_if.sv.
//
// Takes one sprite row per transaction on row_i and emits one pixel column per
// transaction on pix_o, left to right, with the last column flagged. A row gives
// ROW_PIXELS columns, or 2*ROW_PIXELS with expand_x set (24 or 48 by default),
// one column per cycle while pix_o is ready; the column counter sets that
// figure. The next row is taken in the same cycle as the current row's last
// column enters the output register, so rows follow with no gap. Transparent
// columns carry the background colour with opaque low. Row bits above bit 23
// (ROW_PIXELS above 24) and a missing low bit of an odd final multicolour pair
// read as zero. pixel_x wraps to 10 bits. Configuration writes take effect at
// once; index 3 is ignored. A row transaction reaches its first column through
// the row register and then the output register.
module sprite_row_pixel_decoder_core import sprd_pkg::*; #(
  parameter int unsigned ROW_PIXELS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ColorW-1:0]  cfg_data_i,
  sprd_row_if.sink           row_i,
  sprd_pix_if.source         pix_o
);

  localparam int unsigned Cols  = 2 * ROW_PIXELS;
  localparam int unsigned ColW  = $clog2(Cols);
  localparam int unsigned PixW  = $clog2(ROW_PIXELS + 1);
  localparam logic [ColW-1:0] LastNarrow = ColW'(ROW_PIXELS - 1);
  localparam logic [ColW-1:0] LastWide   = ColW'(Cols - 1);

  // Configuration registers
  logic [ColorW-1:0] bg_q, sh1_q, sh2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q  <= ColorW'(0);
      sh1_q <= ColorW'(15);
      sh2_q <= ColorW'(11);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBackground: bg_q  <= cfg_data_i;
        CfgSharedOne:  sh1_q <= cfg_data_i;
        CfgSharedTwo:  sh2_q <= cfg_data_i;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Row register and column counter
  row_item_t       row_q;
  logic            busy_q, busy_d;
  logic [ColW-1:0] col_q, col_d;

  // Output register
  pix_item_t pix_q, pix_d;
  logic      pv_q, pv_d;

  logic row_acc, adv, last_col;

  // While a row is held, advance a column whenever the output register is empty or being drained.
  assign adv      = busy_q && (!pv_q || pix_o.ready);
  assign last_col = col_q == (row_q.expand_x ? LastWide : LastNarrow);
  assign row_i.ready = !busy_q || (adv && last_col);
  assign row_acc  = row_i.valid && row_i.ready;

  // Left-aligned pixel vector: entry k is the k-th pixel from the left, with
  // one extra zero entry for the missing low bit of an odd final pair.
  logic [ROW_PIXELS:0] lft;
  for (genvar k = 0; k <= ROW_PIXELS; k++) begin : g_lft
    if (k < ROW_PIXELS && (ROW_PIXELS - 1 - k) < RowBitsW) begin : g_bit
      assign lft[k] = row_q.row_bits[ROW_PIXELS - 1 - k];
    end else begin : g_zero
      assign lft[k] = 1'b0;
    end
  end

  logic [PixW-1:0]   pidx, hidx;
  logic [1:0]        pair;
  logic [ColorW-1:0] color;
  logic              opq;

  always_comb begin
    pidx = row_q.expand_x ? PixW'(col_q >> 1) : PixW'(col_q);
    hidx = {pidx[PixW-1:1], 1'b0};
    pair = {lft[hidx], lft[hidx + PixW'(1)]};
    color = bg_q;
    opq   = 1'b0;
    if (row_q.multicolor_mode) begin
      case (pair)
        PairShared1: begin color = sh1_q;              opq = 1'b1; end
        PairSprite:  begin color = row_q.sprite_color; opq = 1'b1; end
        PairShared2: begin color = sh2_q;              opq = 1'b1; end
        default: ;   // clear pair: background
      endcase
    end else if (lft[pidx]) begin
      color = row_q.sprite_color;
      opq   = 1'b1;
    end
  end

  always_comb begin
    busy_d = busy_q;
    col_d  = col_q;
    pv_d   = pv_q;
    pix_d  = pix_q;
    if (pv_q && pix_o.ready) begin
      pv_d = 1'b0;
    end
    if (adv) begin
      pv_d              = 1'b1;
      pix_d.pixel_x     = PixelXW'(row_q.start_x) + PixelXW'(col_q);
      pix_d.pixel_y     = row_q.screen_y;
      pix_d.pixel_color = color;
      pix_d.opaque      = opq;
      pix_d.last_pixel  = last_col;
      col_d             = col_q + ColW'(1);
      if (last_col) begin
        busy_d = 1'b0;
      end
    end
    // Hold the new row from column zero.
    if (row_acc) begin
      busy_d = 1'b1;
      col_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      col_q  <= '0;
      pv_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      col_q  <= col_d;
      pv_q   <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
    if (row_acc) begin
      row_q <= row_i.payload;
    end
  end

  assign pix_o.valid   = pv_q;
  assign pix_o.payload = pix_q;

`ifndef NO_ASSERTIONS
  a_accept_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_acc |=> (busy_q && col_q == '0))
    else $error("row transaction did not restart the column counter");

  a_stall_blocks_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && pv_q && !pix_o.ready) |-> !row_i.ready)
    else $error("row taken while its predecessor is stalled");

  a_last_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last_col && !row_acc) |=> (!busy_q && pv_q && pix_o.payload.last_pixel))
    else $error("last column did not end the row");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (col_q <= (row_q.expand_x ? LastWide : LastNarrow)))
    else $error("column counter past the end of the row");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sprite_row_pixel_decoder_core: drives rows and
// register writes, predicts every pixel column and checks it on arrival.
// Depends on sprd_pkg, the channel interfaces in sprd_if.sv and the core.
module testbench;
  import sprd_pkg::*;

  localparam int unsigned RowPx         = 24;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned QuietLimit    = 4000;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned PhaseItems    = 58;
  localparam int unsigned MaxReports    = 60;
  // Index 3 decodes to no register; writes there must be dropped.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef enum int {RxSteady, RxCoin, RxMostly, RxPeriodic} rx_mode_e;

  // Predicts the columns of each accepted row and checks arriving columns.
  class column_tracker;
    logic [ColorW-1:0] background;
    logic [ColorW-1:0] shared_one;
    logic [ColorW-1:0] shared_two;
    pix_item_t         expected_columns[$];
    int unsigned       errors;
    int unsigned       reports;

    function new();
      background = 4'd0;
      shared_one = 4'd15;
      shared_two = 4'd11;
      errors     = 0;
      reports    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [ColorW-1:0] value);
      case (idx)
        CfgBackground: background = value;
        CfgSharedOne:  shared_one = value;
        CfgSharedTwo:  shared_two = value;
        default: ;
      endcase
    endfunction

    // Bits outside the 24-bit row read as zero.
    function bit row_bit_at(logic [RowBitsW-1:0] row, int pos);
      if (pos < 0 || pos >= RowBitsW) return 1'b0;
      return row[pos];
    endfunction

    function void note_row(row_item_t item);
      int        columns;
      int        p;
      int        hi;
      logic [1:0] code;
      pix_item_t px;
      columns = RowPx << item.expand_x;
      for (int c = 0; c < columns; c++) begin
        p              = c >> item.expand_x;
        px.pixel_color = background;
        px.opaque      = 1'b0;
        if (item.multicolor_mode) begin
          hi   = RowPx - 1 - 2 * (p >> 1);
          code = {row_bit_at(item.row_bits, hi), row_bit_at(item.row_bits, hi - 1)};
          case (code)
            PairShared1: begin px.pixel_color = shared_one;        px.opaque = 1'b1; end
            PairSprite:  begin px.pixel_color = item.sprite_color; px.opaque = 1'b1; end
            PairShared2: begin px.pixel_color = shared_two;        px.opaque = 1'b1; end
            default: ;
          endcase
        end else if (row_bit_at(item.row_bits, RowPx - 1 - p)) begin
          px.pixel_color = item.sprite_color;
          px.opaque      = 1'b1;
        end
        px.pixel_x    = {1'b0, item.start_x} + c[PixelXW-1:0];
        px.pixel_y    = item.screen_y;
        px.last_pixel = (c == columns - 1);
        expected_columns.push_back(px);
      end
    endfunction

    function void report(string field, logic [15:0] want, logic [15:0] got);
      errors++;
      if (reports < MaxReports) begin
        reports++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_column(pix_item_t got);
      pix_item_t want;
      if (expected_columns.size() == 0) begin
        report("unexpected column, pixel_x", 16'hffff, got.pixel_x);
        return;
      end
      want = expected_columns.pop_front();
      if (got.pixel_x !== want.pixel_x)         report("pixel_x", want.pixel_x, got.pixel_x);
      if (got.pixel_y !== want.pixel_y)         report("pixel_y", want.pixel_y, got.pixel_y);
      if (got.pixel_color !== want.pixel_color) report("pixel_color", want.pixel_color,
                                                       got.pixel_color);
      if (got.opaque !== want.opaque)           report("opaque", want.opaque, got.opaque);
      if (got.last_pixel !== want.last_pixel)   report("last_pixel", want.last_pixel,
                                                       got.last_pixel);
    endfunction

    function int pending();
      return expected_columns.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ColorW-1:0]  cfg_data_i;
  bit                 hold_off_req = 1'b0;
  int unsigned        quiet_cycles = 0;
  int                 burst_left   = 0;
  column_tracker      board;

  sprd_row_if row_ch ();
  sprd_pix_if pix_ch ();

  sprite_row_pixel_decoder_core #(
    .ROW_PIXELS(RowPx)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .row_i     (row_ch),
    .pix_o     (pix_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Note accepted rows and check accepted columns on the same edge the
  // handshake completes; both sides are sampled before the edge's updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (row_ch.valid && row_ch.ready) board.note_row(row_ch.payload);
      if (pix_ch.valid && pix_ch.ready) board.check_column(pix_ch.payload);
    end
  end

  // Abort when neither channel moves a transaction for too long.
  always @(posedge clk_i) begin
    if ((row_ch.valid && row_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: watchdog: no transaction for %0d cycles", $time, quiet_cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver: segments of random stall patterns, plus one long hold-off that
  // backs the block up until it stalls its row input.
  initial begin
    int       seg_left;
    int       period;
    int       cyc;
    bit       hold_done;
    rx_mode_e mode;
    seg_left     = 0;
    period       = 2;
    cyc          = 0;
    hold_done    = 1'b0;
    mode         = RxSteady;
    pix_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        pix_ch.ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(posedge clk_i);
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(16, 200);
          period   = $urandom_range(2, 8);
        end
        seg_left--;
        case (mode)
          RxSteady:   pix_ch.ready <= 1'b1;
          RxCoin:     pix_ch.ready <= 1'($urandom_range(0, 1));
          RxMostly:   pix_ch.ready <= ($urandom_range(0, 9) != 0);
          RxPeriodic: pix_ch.ready <= ((cyc % period) != 0);
          default:    pix_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  function automatic row_item_t make_row(logic [RowBitsW-1:0] rows, logic [ColorW-1:0] color,
                                         logic multi, logic wide, logic [StartXW-1:0] sx,
                                         logic [LineW-1:0] sy);
    row_item_t item;
    item.row_bits        = rows;
    item.sprite_color    = color;
    item.multicolor_mode = multi;
    item.expand_x        = wide;
    item.start_x         = sx;
    item.screen_y        = sy;
    return item;
  endfunction

  function automatic row_item_t random_row();
    logic [RowBitsW-1:0] rows;
    logic [StartXW-1:0]  sx;
    case ($urandom_range(0, 9))
      0:       rows = '0;
      1:       rows = '1;
      2:       rows = RowBitsW'(8'($urandom)) << (8 * $urandom_range(0, 2));
      default: rows = RowBitsW'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       sx = '0;
      1:       sx = '1;
      default: sx = StartXW'($urandom_range(0, 511));
    endcase
    return make_row(rows, ColorW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), sx, LineW'($urandom_range(0, 255)));
  endfunction

  // Hold valid and payload until the block takes the row.
  task automatic send_row(row_item_t item);
    row_ch.valid   <= 1'b1;
    row_ch.payload <= item;
    do @(posedge clk_i); while (!(row_ch.valid && row_ch.ready));
  endtask

  // Offer rows in bursts; between bursts drop valid for a random gap.
  task automatic offer_row(row_item_t item);
    if (burst_left == 0) begin
      row_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
    end
    send_row(item);
    burst_left--;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ColorW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    board.set_reg(idx, value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted column has come out; step one
  // edge first so the last accepted row has been noted.
  task automatic settle();
    row_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [ColorW-1:0] bg;
    logic [ColorW-1:0] one;
    logic [ColorW-1:0] two;
    board          = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CfgBackground;
    cfg_data_i     = '0;
    row_ch.valid   = 1'b0;
    row_ch.payload = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed rows under the reset register values: field extremes, every
    // pair code, both modes and widths, edge pixels.
    offer_row(make_row(24'hFFFFFF, 4'd15, 1'b0, 1'b0, 9'd0,   8'd0));
    offer_row(make_row(24'h000000, 4'd15, 1'b0, 1'b0, 9'd511, 8'd255));
    offer_row(make_row(24'hFFFFFF, 4'd0,  1'b1, 1'b1, 9'd511, 8'd255));
    offer_row(make_row(24'h000000, 4'd7,  1'b1, 1'b1, 9'd0,   8'd0));
    offer_row(make_row(24'h1B1B1B, 4'd9,  1'b1, 1'b0, 9'd100, 8'd10));
    offer_row(make_row(24'h1B1B1B, 4'd9,  1'b1, 1'b1, 9'd300, 8'd11));
    offer_row(make_row(24'hE4E4E4, 4'd3,  1'b1, 1'b0, 9'd490, 8'd12));
    offer_row(make_row(24'hAAAAAA, 4'd5,  1'b0, 1'b1, 9'd17,  8'd13));
    offer_row(make_row(24'h555555, 4'd5,  1'b1, 1'b0, 9'd18,  8'd14));
    offer_row(make_row(24'hAAAAAA, 4'd12, 1'b1, 1'b0, 9'd19,  8'd15));
    offer_row(make_row(24'h800001, 4'd15, 1'b0, 1'b1, 9'd511, 8'd128));
    offer_row(make_row(24'h800001, 4'd6,  1'b1, 1'b1, 9'd1,   8'd127));
    offer_row(make_row(24'hFF0000, 4'd1,  1'b0, 1'b0, 9'd255, 8'd170));
    offer_row(make_row(24'h0000FF, 4'd2,  1'b0, 1'b0, 9'd256, 8'd85));
    offer_row(make_row(24'h00FF00, 4'd14, 1'b1, 1'b1, 9'd256, 8'd1));
    offer_row(make_row(24'h3C3C3C, 4'd8,  1'b0, 1'b0, 9'd170, 8'd254));
    settle();

    // Random phases, each under its own register setting; the first two
    // are the all-zero and all-ones extremes.
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: begin bg = 4'd0;  one = 4'd0;  two = 4'd0;  end
        1: begin bg = 4'd15; one = 4'd15; two = 4'd15; end
        default: begin
          bg  = ColorW'($urandom_range(0, 15));
          one = ColorW'($urandom_range(0, 15));
          two = ColorW'($urandom_range(0, 15));
        end
      endcase
      write_reg(CfgBackground, bg);
      write_reg(CfgSharedOne, one);
      write_reg(CfgSharedTwo, two);
      // Write the unused index last so any aliasing shows up.
      write_reg(CfgUnused, ColorW'($urandom_range(0, 15)));
      if (k == 1) hold_off_req <= 1'b1;
      for (int i = 0; i < PhaseItems; i++) offer_row(random_row());
      settle();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
